// ===== hw/rtl/ssfl_pkg.sv =====
`default_nettype none

package ssfl_pkg;

  localparam int BYTE_W        = 8;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int LENGTH_W      = 6;
  localparam int PATTERN_WORDS = 4;
  localparam int PATTERN_BYTES = 32;
  localparam int PATTERN_W     = PATTERN_BYTES * BYTE_W;
  localparam int RESULT_OFS_W  = 32;
  // Wide enough for any byte index up to the largest pattern (32 bytes).
  localparam int WIDE_IDX_W    = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEARCH_MODE    = 3'd0,
    REG_PATTERN_LENGTH = 3'd1,
    REG_PATTERN_0_7    = 3'd2,
    REG_PATTERN_8_15   = 3'd3,
    REG_PATTERN_16_23  = 3'd4,
    REG_PATTERN_24_31  = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/substring_search_first_last.sv =====
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    text_byte, final_byte
// out      out_valid / out_ready  match_found, match_offset
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while results are taken: an input register feeds the window
// compare, whose result lands in the output register as the byte leaves the input
// register. The output register is refilled in the cycle it is read, so stalls
// cost nothing while out_ready stays high. A result held by out_ready low keeps
// the input register full, so in_ready drops until that result is taken.
// rst clears all control state and the configuration; the window needs no clearing.
module substring_search_first_last
  import ssfl_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [BYTE_W-1:0]       text_byte,
  input  wire logic                    final_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         match_found,
  output logic [RESULT_OFS_W-1:0]      match_offset,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic                  search_mode;
  logic [LENGTH_W-1:0]   pattern_length;
  logic [CFG_DATA_W-1:0] pattern_word [PATTERN_WORDS];
  logic [PATTERN_W-1:0]  pattern;
  logic [LEN_W-1:0]      len;

  logic                  s1_valid;
  logic [BYTE_W-1:0]     s1_byte;
  logic                  s1_final;
  logic                  s1_go;

  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   have_match;
  logic [OFFSET_BITS-1:0] best_offset;
  logic                   already_reported;

  logic                   bytes_equal;
  logic [OFFSET_BITS-1:0] seen_next;
  logic [OFFSET_BITS-1:0] start_ofs;
  logic                   hit;
  logic                   have_match_next;
  logic [OFFSET_BITS-1:0] best_offset_next;
  logic                   fwd_emit;
  logic                   emit;
  logic                   found_next;
  logic [OFFSET_BITS-1:0] offset_next;

  assign cfg_ready = 1'b1;
  assign pattern   = {pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]};
  assign len = (WIDE_IDX_W'(pattern_length) > WIDE_IDX_W'(MAX_PATTERN))
             ? LEN_W'(MAX_PATTERN) : LEN_W'(pattern_length);

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  ssfl_window #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_window (
    .clk        (clk),
    .shift_en   (s1_go),
    .text_byte  (s1_byte),
    .len        (len),
    .pattern    (pattern),
    .bytes_equal(bytes_equal)
  );

  always_comb begin
    seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + 1'b1;
    start_ofs = seen_next - OFFSET_BITS'(len);
    hit = (len != '0) && (seen_next >= OFFSET_BITS'(len)) && bytes_equal;
    have_match_next  = have_match || hit;
    best_offset_next = hit ? start_ofs : best_offset;

    fwd_emit    = !search_mode && !already_reported && ((len == '0) || hit);
    emit        = 1'b0;
    found_next  = 1'b0;
    offset_next = '0;
    if (fwd_emit) begin
      emit        = 1'b1;
      found_next  = 1'b1;
      offset_next = (len == '0) ? '0 : start_ofs;
    end else if (s1_final) begin
      if (search_mode) begin
        emit = 1'b1;
        if (len == '0) begin
          found_next  = 1'b1;
          offset_next = seen_next;
        end else if (have_match_next) begin
          found_next  = 1'b1;
          offset_next = best_offset_next;
        end
      end else if (!already_reported) begin
        emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode    <= 1'b0;
      pattern_length <= '0;
      for (int i = 0; i < PATTERN_WORDS; i++) begin
        pattern_word[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEARCH_MODE:    search_mode     <= cfg_data[0];
        REG_PATTERN_LENGTH: pattern_length  <= cfg_data[LENGTH_W-1:0];
        REG_PATTERN_0_7:    pattern_word[0] <= cfg_data;
        REG_PATTERN_8_15:   pattern_word[1] <= cfg_data;
        REG_PATTERN_16_23:  pattern_word[2] <= cfg_data;
        REG_PATTERN_24_31:  pattern_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte  <= text_byte;
      s1_final <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen       <= '0;
      have_match       <= 1'b0;
      best_offset      <= '0;
      already_reported <= 1'b0;
    end else if (s1_go) begin
      if (s1_final) begin
        bytes_seen       <= '0;
        have_match       <= 1'b0;
        best_offset      <= '0;
        already_reported <= 1'b0;
      end else begin
        bytes_seen       <= seen_next;
        have_match       <= have_match_next;
        best_offset      <= best_offset_next;
        already_reported <= already_reported || fwd_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && emit) begin
      match_found  <= found_next;
      match_offset <= RESULT_OFS_W'(offset_next);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssfl_window.sv =====
`default_nettype none

// Byte window (entry 0 newest) and a parallel compare of its newest len bytes,
// including the byte being shifted in, against the pattern in reverse order.
module ssfl_window
  import ssfl_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic                               clk,
  input  wire logic                               shift_en,
  input  wire logic [BYTE_W-1:0]                  text_byte,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]   len,
  input  wire logic [PATTERN_W-1:0]               pattern,
  output logic                                    bytes_equal
);

  logic [BYTE_W-1:0]     window [MAX_PATTERN];
  logic [BYTE_W-1:0]     cur    [MAX_PATTERN];
  logic [WIDE_IDX_W-1:0] pidx   [MAX_PATTERN];
  logic [BYTE_W-1:0]     pbyte  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] lane_ok;

  always_comb begin
    cur[0] = text_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      cur[i] = window[i-1];
    end
  end

  // Window contents older than the current haystack never reach the compare,
  // since a lane counts only when at least len bytes have been seen.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window[i] <= cur[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pidx[i] = WIDE_IDX_W'(len) - WIDE_IDX_W'(1) - WIDE_IDX_W'(i);
      if (pidx[i] < WIDE_IDX_W'(PATTERN_BYTES)) begin
        pbyte[i] = pattern[pidx[i][4:0]*BYTE_W +: BYTE_W];
      end else begin
        pbyte[i] = '0;
      end
      lane_ok[i] = (WIDE_IDX_W'(i) >= WIDE_IDX_W'(len)) || (cur[i] == pbyte[i]);
    end
    bytes_equal = &lane_ok;
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

typedef struct packed {
  logic                              found;
  logic [ssfl_pkg::RESULT_OFS_W-1:0] ofs;
} search_result_t;

// Tracks the search state of the block and holds the results it still owes.
class match_tracker;
  bit             mode;
  bit [5:0]       pat_len;
  bit [63:0]      pat_word [4];
  bit [7:0]       window [32];
  bit [31:0]      seen;
  bit             have_hit;
  bit [31:0]      best;
  bit             reported;
  search_result_t results_due [$];
  int             errors;

  function new();
    errors  = 0;
    mode    = 1'b0;
    pat_len = '0;
    foreach (pat_word[i]) pat_word[i] = '0;
    clear_stream();
  endfunction

  function void clear_stream();
    foreach (window[i]) window[i] = '0;
    seen     = '0;
    have_hit = 1'b0;
    best     = '0;
    reported = 1'b0;
  endfunction

  function void queue_result(bit found, bit [31:0] ofs);
    search_result_t r;
    r.found = found;
    r.ofs   = ofs;
    results_due.push_back(r);
  endfunction

  function void apply_reg(ssfl_pkg::cfg_reg_t idx, bit [63:0] data);
    case (idx)
      ssfl_pkg::REG_SEARCH_MODE:    mode = data[0];
      ssfl_pkg::REG_PATTERN_LENGTH: pat_len = data[5:0];
      ssfl_pkg::REG_PATTERN_0_7:    pat_word[0] = data;
      ssfl_pkg::REG_PATTERN_8_15:   pat_word[1] = data;
      ssfl_pkg::REG_PATTERN_16_23:  pat_word[2] = data;
      ssfl_pkg::REG_PATTERN_24_31:  pat_word[3] = data;
      default: ;
    endcase
  endfunction

  function void note_byte(bit [7:0] b, bit fin);
    int len;
    int idx;
    bit hit;
    bit queued;
    len    = (pat_len > 32) ? 32 : int'(pat_len);
    queued = 1'b0;
    for (int i = 31; i > 0; i--) window[i] = window[i-1];
    window[0] = b;
    if (seen != '1) seen++;
    // The newest byte lines up with the last pattern byte.
    hit = (len > 0) && (seen >= len);
    for (int i = 0; i < len; i++) begin
      idx = len - 1 - i;
      if (window[i] != pat_word[idx >> 3][(idx & 7) * 8 +: 8]) hit = 1'b0;
    end
    if (hit) begin
      have_hit = 1'b1;
      best     = seen - len;
    end
    if (!mode && !reported) begin
      if (len == 0) begin
        queue_result(1'b1, '0);
        reported = 1'b1;
        queued   = 1'b1;
      end else if (hit) begin
        queue_result(1'b1, best);
        reported = 1'b1;
        queued   = 1'b1;
      end
    end
    if (fin) begin
      if (!queued) begin
        if (mode) begin
          if (len == 0) queue_result(1'b1, seen);
          else if (have_hit) queue_result(1'b1, best);
          else queue_result(1'b0, '0);
        end else if (!reported) begin
          queue_result(1'b0, '0);
        end
      end
      clear_stream();
    end
  endfunction

  function void check_result(bit found, bit [31:0] ofs);
    search_result_t want;
    if (results_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: found=%0d offset=%0d", found, ofs);
      return;
    end
    want = results_due.pop_front();
    if (want.found !== found || want.ofs !== ofs) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: expected found=%0d offset=%0d, got found=%0d offset=%0d",
                 want.found, want.ofs, found, ofs);
    end
  endfunction

  function int pending();
    return results_due.size();
  endfunction
endclass

module tb_top;
  import ssfl_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int ITEM_TARGET = 2000;
  localparam int CALM_FROM   = 1700;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [BYTE_W-1:0]       text_byte = '0;
  logic                    final_byte = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    match_found;
  logic [RESULT_OFS_W-1:0] match_offset;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  cfg_reg_t                cfg_index = REG_SEARCH_MODE;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  match_tracker sb;
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;
  int           items_sent = 0;
  bit [7:0]     pat [32];
  int           len_cfg = 0;

  always #5 clk = ~clk;

  substring_search_first_last u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_found  (match_found),
    .match_offset (match_offset),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall bursts, or one long hold when asked for.
  initial begin : receiver
    int burst;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst     = $urandom_range(1, 16);
        out_ready = 1'b0;
        repeat (burst) @(negedge clk);
      end
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(match_found, match_offset);
  end

  // Leaves cfg_valid high so back-to-back writes need no toggle; callers lower it.
  task automatic cfg_write(input cfg_reg_t idx, input bit [63:0] data);
    int base;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, data);
    case (idx)
      REG_SEARCH_MODE: ;
      REG_PATTERN_LENGTH: len_cfg = (data[5:0] > 32) ? 32 : int'(data[5:0]);
      default: begin
        base = (int'(idx) - int'(REG_PATTERN_0_7)) * 8;
        for (int k = 0; k < 8; k++) pat[base + k] = data[k * 8 +: 8];
      end
    endcase
    @(negedge clk);
  endtask

  task automatic send_byte(input bit [7:0] b, input bit fin);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap      = $urandom_range(1, 16);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    text_byte  = b;
    final_byte = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, fin);
    items_sent++;
    @(negedge clk);
  endtask

  // Waits until every owed result has arrived and the pipeline is empty.
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // A haystack of random content, often built from pattern bytes with the
  // pattern planted a few times so that partial and overlapping matches occur.
  task automatic send_haystack(input int n, input bit close);
    bit [7:0] hay [];
    bit [7:0] x;
    bit [7:0] y;
    int       style;
    int       plants;
    int       pos;
    hay    = new[n];
    style  = $urandom_range(0, 3);
    x      = $urandom;
    y      = $urandom;
    plants = 0;
    for (int i = 0; i < n; i++) begin
      case (style)
        0:       hay[i] = $urandom;
        2:       hay[i] = $urandom_range(0, 1) ? x : y;
        default: hay[i] = pat[$urandom_range(0, (len_cfg > 0) ? len_cfg - 1 : 0)];
      endcase
    end
    if (style != 0 && len_cfg > 0 && len_cfg <= n) plants = $urandom_range(0, 2);
    for (int p = 0; p < plants; p++) begin
      pos = $urandom_range(0, n - len_cfg);
      for (int k = 0; k < len_cfg; k++) hay[pos + k] = pat[k];
    end
    for (int i = 0; i < n; i++) send_byte(hay[i], close && (i == n - 1));
  endtask

  initial begin : main
    bit [63:0] w;
    bit [7:0]  x;
    bit [7:0]  y;
    bit        alph;
    bit        first;
    int        r;
    int        nh;
    int        n;
    int        wait_cycles;
    sb = new();
    foreach (pat[i]) pat[i] = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Empty pattern, forward: reported on the first byte, nothing at the end.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
    // Empty pattern, reverse: the haystack length comes back.
    cfg_write(REG_SEARCH_MODE, 64'd1);
    cfg_valid = 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);
    settle();
    // Two-byte pattern found three times: reverse reports the latest start.
    cfg_write(REG_PATTERN_0_7, 64'h0123_4567_89AB_00FF);
    cfg_write(REG_PATTERN_LENGTH, 64'd2);
    cfg_valid = 1'b0;
    repeat (2) begin
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
    end
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();
    // Same in forward mode: the first start, and the final byte stays silent.
    cfg_write(REG_SEARCH_MODE, 64'd0);
    cfg_valid = 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();
    // Pattern longer than the haystack finds nothing in either mode.
    cfg_write(REG_PATTERN_0_7, 64'hAAAA_AAAA_AAAA_AAAA);
    cfg_write(REG_PATTERN_8_15, 64'hAAAA_AAAA_AAAA_AAAA);
    cfg_write(REG_PATTERN_16_23, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_PATTERN_24_31, 64'h0000_0000_0000_0000);
    cfg_write(REG_PATTERN_LENGTH, 64'd32);
    cfg_write(REG_SEARCH_MODE, 64'd1);
    cfg_valid = 1'b0;
    send_byte(8'hAA, 1'b1);
    settle();
    cfg_write(REG_SEARCH_MODE, 64'd0);
    cfg_valid = 1'b0;
    send_byte(8'hAA, 1'b1);
    settle();
    // A mode change inside a haystack gives a forward and a reverse result.
    cfg_write(REG_PATTERN_0_7, 64'hFFFF_FFFF_FFFF_FF42);
    cfg_write(REG_PATTERN_LENGTH, 64'd1);
    cfg_valid = 1'b0;
    send_byte(8'h42, 1'b0);
    settle();
    cfg_write(REG_SEARCH_MODE, 64'd1);
    cfg_valid = 1'b0;
    send_byte(8'h42, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    // Long receiver hold while one-byte haystacks keep coming, so the block
    // backs up and drops in_ready.
    cfg_write(REG_SEARCH_MODE, 64'd0);
    cfg_write(REG_PATTERN_LENGTH, 64'd0);
    cfg_valid = 1'b0;
    calm      = 1'b1;
    hold_req  = 1'b1;
    wait (hold_req == 1'b0);
    repeat (60) send_byte($urandom, 1'b1);
    settle();

    first = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      settle();
      calm = (items_sent >= CALM_FROM) || ($urandom_range(0, 3) == 0);
      cfg_write(REG_SEARCH_MODE, 64'($urandom_range(0, 1)));
      r = $urandom_range(0, 19);
      if (r < 2) n = 0;
      else if (r < 4) n = 32;
      else if (r < 5) n = $urandom_range(33, 63);
      else if (r < 8) n = 1;
      else n = $urandom_range(2, 8);
      cfg_write(REG_PATTERN_LENGTH, 64'(n));
      alph = $urandom_range(0, 2) != 0;
      x    = $urandom;
      y    = ($urandom_range(0, 3) == 0) ? x : 8'($urandom);
      for (int k = 0; k < 4; k++) begin
        if (first || $urandom_range(0, 1) == 1) begin
          for (int j = 0; j < 8; j++)
            w[j * 8 +: 8] = alph ? ($urandom_range(0, 1) ? x : y) : 8'($urandom);
          cfg_write(cfg_reg_t'(int'(REG_PATTERN_0_7) + k), w);
        end
      end
      cfg_valid = 1'b0;
      first     = 1'b0;
      nh        = $urandom_range(1, 6);
      for (int h = 0; h < nh; h++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        // Now and then the phase ends inside a haystack, so the next
        // configuration lands mid-stream.
        send_haystack(n, !(h == nh - 1 && $urandom_range(0, 7) == 0));
      end
    end

    in_valid    = 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
